@@ hw/rtl/billboard_corner_generator_top_macros.svh @@
// ----------------------------------------------------------------------------
// Billboard corner generator assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BILLBOARD_CORNER_GENERATOR_TOP_MACROS_SVH
`define BILLBOARD_CORNER_GENERATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define BCG_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("bcg assertion failed");
// Check that the consequent holds in the cycle after the antecedent.
`define BCG_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("bcg assertion failed");
`else
`define BCG_ASSERT(lbl, clk, rstn, prop)
`define BCG_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ hw/rtl/bcg_pkg.sv @@
// ----------------------------------------------------------------------------
// Billboard corner generator package
// Widths, stage positions and cell payload types shared by the RTL files.
// ----------------------------------------------------------------------------
`default_nettype none
package bcg_pkg;

	localparam int MAG_W      = 16;
	localparam int LANES      = 5;
	localparam int ROOT_W     = 24;
	localparam int RAD_W      = 2 * ROOT_W;
	localparam int SQREM_W    = ROOT_W + 2;
	localparam int DREM_W     = ROOT_W;
	localparam int SQRT_CELLS = ROOT_W;
	localparam int DIV_CELLS  = 15;
	localparam int QUO_W      = DIV_CELLS;

	// stage numbers, stage 1 is the input register
	localparam int STG_VEC    = 6;
	localparam int STG_SQRT0  = 9;
	localparam int STG_DPREP  = STG_SQRT0 + SQRT_CELLS;
	localparam int STG_CLAMP  = STG_DPREP + DIV_CELLS + 1;
	localparam int PIPE_DEPTH = STG_CLAMP + 1;
	localparam int VEC_DEPTH  = STG_CLAMP - STG_VEC;

	localparam logic [14:0] ONE_Q14 = 15'd16384;

	typedef struct packed {
		logic             neg;
		logic [MAG_W-1:0] mag;
	} sm_t;

	typedef sm_t [LANES-1:0] vec_t;

	typedef struct packed {
		logic [SQREM_W-1:0] rem;
		logic [ROOT_W-1:0]  root;
		logic [RAD_W-1:0]   rad;
	} sqrt_cell_t;

	typedef struct packed {
		logic [DREM_W-1:0] rem;
		logic [QUO_W-1:0]  num;
		logic [QUO_W-1:0]  quo;
		logic [ROOT_W-1:0] dvs;
		logic              sat;
		logic              zero;
	} div_cell_t;

endpackage
`default_nettype wire

@@ hw/rtl/bcg_sin.sv @@
// ----------------------------------------------------------------------------
// Sine lane
// Four-stage quarter-wave polynomial sine of a 16-bit binary angle, Q2.14.
// ----------------------------------------------------------------------------
`default_nettype none
module bcg_sin (
	input  logic         clk,
	input  logic         en,
	input  logic [15:0]  angle,
	output bcg_pkg::sm_t res
);
	import bcg_pkg::*;

	localparam logic [14:0] QTR   = 15'd16384;
	localparam logic [12:0] COEF_C = 13'd4640;
	localparam logic [15:0] COEF_B = 16'd42047;
	localparam logic [16:0] COEF_A = 17'd102944;

	logic [14:0] x;
	logic [29:0] xx;
	logic [14:0] x_s1, x2_s1, x2_s2, x_s2, x_s3;
	logic        neg_s1, neg_s2, neg_s3;
	logic [27:0] p2;
	logic [15:0] t2_s2;
	logic [30:0] p3;
	logic [16:0] t4_s3;
	logic [31:0] p4;
	logic [17:0] t5r;
	logic [15:0] t6;

	// odd quadrants run the quarter wave backwards
	assign x  = angle[14] ? 15'(QTR - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
	assign xx = x * x;
	assign p2 = COEF_C * x2_s1;
	assign p3 = t2_s2 * x2_s2;
	assign p4 = t4_s3 * x_s3;
	assign t5r = p4[31:14] + 18'd2;
	assign t6  = t5r[17:2];

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= x;
			x2_s1  <= xx[28:14];
			neg_s1 <= angle[15];
			x_s2   <= x_s1;
			x2_s2  <= x2_s1;
			neg_s2 <= neg_s1;
			t2_s2  <= COEF_B - {2'b00, p2[27:14]};
			x_s3   <= x_s2;
			neg_s3 <= neg_s2;
			t4_s3  <= COEF_A - p3[30:14];
			res.neg <= neg_s3;
			res.mag <= (t6 > {1'b0, ONE_Q14}) ? {1'b0, ONE_Q14} : t6;
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/bcg_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// Square root cell
// One root bit per cell of a digit-by-digit integer square root.
// ----------------------------------------------------------------------------
`default_nettype none
module bcg_sqrt_cell (
	input  logic                clk,
	input  logic                en,
	input  bcg_pkg::sqrt_cell_t d_in,
	output bcg_pkg::sqrt_cell_t d_out
);
	import bcg_pkg::*;

	logic [SQREM_W-1:0] r2;
	logic [SQREM_W-1:0] trial;
	logic               ge;

	// bring down the next two radicand bits
	assign r2    = {d_in.rem[SQREM_W-3:0], d_in.rad[RAD_W-1 -: 2]};
	assign trial = {d_in.root, 2'b01};
	assign ge    = r2 >= trial;

	always_ff @(posedge clk) begin
		if (en) begin
			d_out.rem  <= ge ? (r2 - trial) : r2;
			d_out.root <= {d_in.root[ROOT_W-2:0], ge};
			d_out.rad  <= {d_in.rad[RAD_W-3:0], 2'b00};
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/bcg_div_cell.sv @@
// ----------------------------------------------------------------------------
// Divider cell
// One quotient bit per cell of a restoring division.
// ----------------------------------------------------------------------------
`default_nettype none
module bcg_div_cell (
	input  logic               clk,
	input  logic               en,
	input  bcg_pkg::div_cell_t d_in,
	output bcg_pkg::div_cell_t d_out
);
	import bcg_pkg::*;

	logic [DREM_W:0] r2;
	logic [DREM_W:0] diff;
	logic            ge;

	assign r2   = {d_in.rem, d_in.num[QUO_W-1]};
	assign diff = r2 - {1'b0, d_in.dvs};
	assign ge   = r2 >= {1'b0, d_in.dvs};

	always_ff @(posedge clk) begin
		if (en) begin
			d_out.rem  <= ge ? diff[DREM_W-1:0] : r2[DREM_W-1:0];
			d_out.num  <= {d_in.num[QUO_W-2:0], 1'b0};
			d_out.quo  <= {d_in.quo[QUO_W-2:0], ge};
			d_out.dvs  <= d_in.dvs;
			d_out.sat  <= d_in.sat;
			d_out.zero <= d_in.zero;
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/billboard_corner_generator_top.sv @@
// ----------------------------------------------------------------------------
// Billboard corner generator
// Camera-facing quad corners A, B, C, D from yaw, up vector and centre.
// ----------------------------------------------------------------------------
// An accepted item passes a 50-stage chain (sines, vector build, squares, a
// 24-cell square root, a 15-cell divider per component, offsets) and then
// the output stage, which issues the four corners one after another. The
// chain takes a new item only while the output stage is empty or issues its
// last corner; the whole chain holds while a corner waits.
`default_nettype none
`include "billboard_corner_generator_top_macros.svh"
module billboard_corner_generator_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] cam_yaw,
	input  logic signed [15:0] cam_up_x,
	input  logic signed [15:0] cam_up_y,
	input  logic signed [15:0] cam_up_z,
	input  logic signed [31:0] center_x,
	input  logic signed [31:0] center_y,
	input  logic signed [31:0] center_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         corner_index,
	output logic signed [31:0] corner_x,
	output logic signed [31:0] corner_y,
	output logic signed [31:0] corner_z,
	output logic               last_corner
);
	import bcg_pkg::*;

	typedef enum logic [2:0] {
		REG_WIDTH, REG_HEIGHT, REG_YAW_FIX, REG_PITCH_FIX, REG_FIX_YAW, REG_FIX_PITCH
	} reg_idx_t;

	localparam int NORM_SHIFT = 22;
	localparam int NUM_W      = MAG_W + NORM_SHIFT;
	localparam logic [15:0] QUARTER = 16'h4000;

	reg_idx_t    reg_idx;
	logic [31:0] width_q, height_q;
	logic        yaw_fix_q, pitch_fix_q;
	logic [15:0] fix_yaw_q, fix_pitch_q;

	logic adv, accept;
	logic [PIPE_DEPTH-1:0] vld_q;
	logic [2:0][31:0] cpipe_q [PIPE_DEPTH];
	logic [2:0][15:0] upd_q [STG_VEC-1];
	logic [15:0] yaw_s1;

	sm_t sy, cy, sp, cp;
	vec_t vec_d;
	vec_t vec_q [VEC_DEPTH];
	logic [31:0] sq_s7 [LANES];
	logic [31:0] l2r_s8, l2u_s8;

	sqrt_cell_t sq_seed [2];
	sqrt_cell_t sqo [2][SQRT_CELLS];
	div_cell_t  dprep_d [LANES];
	div_cell_t  dprep_s33 [LANES];
	div_cell_t  dcell [LANES][DIV_CELLS];
	sm_t        clamp_d [LANES];
	sm_t        comp_s49 [LANES];
	logic signed [32:0] off_d [LANES];
	logic signed [32:0] off_s50 [LANES];

	logic               hold_valid_q;
	logic [1:0]         cnt_q;
	logic [2:0][31:0]   hc_q;
	logic signed [32:0] hoff_q [LANES];

	function automatic sm_t to_sm(input logic [15:0] v);
		sm_t r;
		r.neg = v[15];
		r.mag = v[15] ? (~v + 16'd1) : v;
		return r;
	endfunction

	function automatic logic [15:0] mul_mag(input logic [14:0] a, input logic [14:0] b);
		logic [29:0] p;
		p = a * b + 30'd8192;
		return p[29:14];
	endfunction

	function automatic logic signed [31:0] corner(input logic signed [31:0] c,
			input logic signed [32:0] ro, input logic signed [32:0] uo,
			input logic [1:0] k);
		logic signed [34:0] r35, u35, s;
		r35 = 35'(ro);
		u35 = 35'(uo);
		s = 35'(c) + (k[0] ? r35 : -r35) + (k[1] ? u35 : -u35);
		if (s > 35'sd2147483647)
			return 32'sh7fffffff;
		else if (s < -35'sd2147483648)
			return 32'sh80000000;
		else
			return s[31:0];
	endfunction

	// configuration port
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[4:2]);

	always_comb begin
		case (reg_idx)
			REG_WIDTH:     prdata = width_q;
			REG_HEIGHT:    prdata = height_q;
			REG_YAW_FIX:   prdata = {31'b0, yaw_fix_q};
			REG_PITCH_FIX: prdata = {31'b0, pitch_fix_q};
			REG_FIX_YAW:   prdata = {16'b0, fix_yaw_q};
			REG_FIX_PITCH: prdata = {16'b0, fix_pitch_q};
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= 32'd131072;
			height_q    <= 32'd131072;
			yaw_fix_q   <= 1'b0;
			pitch_fix_q <= 1'b0;
			fix_yaw_q   <= '0;
			fix_pitch_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_WIDTH:     width_q     <= pwdata;
				REG_HEIGHT:    height_q    <= pwdata;
				REG_YAW_FIX:   yaw_fix_q   <= pwdata[0];
				REG_PITCH_FIX: pitch_fix_q <= pwdata[0];
				REG_FIX_YAW:   fix_yaw_q   <= pwdata[15:0];
				REG_FIX_PITCH: fix_pitch_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// advance the chain whenever the output stage can take its next item
	assign adv      = !hold_valid_q || (!out_stall && cnt_q == 2'd3);
	assign in_stall = !adv;
	assign accept   = in_valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[PIPE_DEPTH-2:0], accept};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			yaw_s1     <= yaw_fix_q ? fix_yaw_q : cam_yaw;
			upd_q[0]   <= {cam_up_z, cam_up_y, cam_up_x};
			cpipe_q[0] <= {center_z, center_y, center_x};
			for (int i = 1; i < STG_VEC - 1; i++)
				upd_q[i] <= upd_q[i-1];
			for (int i = 1; i < PIPE_DEPTH; i++)
				cpipe_q[i] <= cpipe_q[i-1];
		end
	end

	bcg_sin u_sin_yaw (.clk(clk), .en(adv), .angle(yaw_s1), .res(sy));
	bcg_sin u_cos_yaw (.clk(clk), .en(adv), .angle(yaw_s1 + QUARTER), .res(cy));
	bcg_sin u_sin_pitch (.clk(clk), .en(adv), .angle(fix_pitch_q), .res(sp));
	bcg_sin u_cos_pitch (.clk(clk), .en(adv), .angle(fix_pitch_q + QUARTER), .res(cp));

	// right = (sin yaw, 0, -cos yaw); y lane of right is always zero and dropped
	always_comb begin
		vec_d[0] = sy;
		vec_d[1] = '{neg: !cy.neg, mag: cy.mag};
		if (pitch_fix_q) begin
			vec_d[2] = '{neg: !(cy.neg ^ sp.neg), mag: mul_mag(cy.mag[14:0], sp.mag[14:0])};
			vec_d[3] = cp;
			vec_d[4] = '{neg: !(sy.neg ^ sp.neg), mag: mul_mag(sy.mag[14:0], sp.mag[14:0])};
		end else begin
			vec_d[2] = to_sm(upd_q[STG_VEC-2][0]);
			vec_d[3] = to_sm(upd_q[STG_VEC-2][1]);
			vec_d[4] = to_sm(upd_q[STG_VEC-2][2]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vec_q[0] <= vec_d;
			for (int i = 1; i < VEC_DEPTH; i++)
				vec_q[i] <= vec_q[i-1];
			for (int l = 0; l < LANES; l++)
				sq_s7[l] <= vec_q[0][l].mag * vec_q[0][l].mag;
			l2r_s8 <= sq_s7[0] + sq_s7[1];
			l2u_s8 <= sq_s7[2] + sq_s7[3] + sq_s7[4];
		end
	end

	always_comb begin
		sq_seed[0] = '{rem: '0, root: '0, rad: {l2r_s8, 16'b0}};
		sq_seed[1] = '{rem: '0, root: '0, rad: {l2u_s8, 16'b0}};
	end

	for (genvar v = 0; v < 2; v++) begin : g_sqv
		for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_cell
			if (i == 0) begin : g_first
				bcg_sqrt_cell u_cell (.clk(clk), .en(adv), .d_in(sq_seed[v]),
					.d_out(sqo[v][i]));
			end else begin : g_next
				bcg_sqrt_cell u_cell (.clk(clk), .en(adv), .d_in(sqo[v][i-1]),
					.d_out(sqo[v][i]));
			end
		end
	end

	// numerator m * 2^22 + s/2; a top part not below s means the quotient clamps
	always_comb begin
		logic [ROOT_W-1:0] dv;
		logic [NUM_W-1:0]  num;
		for (int l = 0; l < LANES; l++) begin
			dv  = (l < 2) ? sqo[0][SQRT_CELLS-1].root : sqo[1][SQRT_CELLS-1].root;
			num = {vec_q[STG_DPREP-1-STG_VEC][l].mag, {NORM_SHIFT{1'b0}}}
				+ NUM_W'(dv[ROOT_W-1:1]);
			dprep_d[l].rem  = {1'b0, num[NUM_W-1:QUO_W]};
			dprep_d[l].num  = num[QUO_W-1:0];
			dprep_d[l].quo  = '0;
			dprep_d[l].dvs  = dv;
			dprep_d[l].sat  = {1'b0, num[NUM_W-1:QUO_W]} >= dv;
			dprep_d[l].zero = dv == '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < LANES; l++)
				dprep_s33[l] <= dprep_d[l];
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_divl
		for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cell
			if (i == 0) begin : g_first
				bcg_div_cell u_cell (.clk(clk), .en(adv), .d_in(dprep_s33[l]),
					.d_out(dcell[l][i]));
			end else begin : g_next
				bcg_div_cell u_cell (.clk(clk), .en(adv), .d_in(dcell[l][i-1]),
					.d_out(dcell[l][i]));
			end
		end
	end

	always_comb begin
		logic [46:0] p;
		logic [46:0] pr;
		for (int l = 0; l < LANES; l++) begin
			clamp_d[l].neg = vec_q[STG_CLAMP-1-STG_VEC][l].neg;
			if (dcell[l][DIV_CELLS-1].zero)
				clamp_d[l].mag = '0;
			else if (dcell[l][DIV_CELLS-1].sat || dcell[l][DIV_CELLS-1].quo > ONE_Q14)
				clamp_d[l].mag = {1'b0, ONE_Q14};
			else
				clamp_d[l].mag = {1'b0, dcell[l][DIV_CELLS-1].quo};
			p  = ((l < 2) ? width_q : height_q) * comp_s49[l].mag[14:0];
			pr = p + 47'd16384;
			off_d[l] = comp_s49[l].neg ? -$signed({1'b0, pr[46:15]})
				: $signed({1'b0, pr[46:15]});
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < LANES; l++) begin
				comp_s49[l] <= clamp_d[l];
				off_s50[l]  <= off_d[l];
			end
		end
	end

	// output stage: one corner per cycle while out_stall is low, A first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			cnt_q        <= '0;
		end else if (adv) begin
			hold_valid_q <= vld_q[PIPE_DEPTH-1];
			cnt_q        <= '0;
		end else if (!out_stall) begin
			cnt_q <= cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hc_q <= cpipe_q[PIPE_DEPTH-1];
			for (int l = 0; l < LANES; l++)
				hoff_q[l] <= off_s50[l];
		end
	end

	assign out_valid    = hold_valid_q;
	assign corner_index = cnt_q;
	assign last_corner  = cnt_q == 2'd3;
	assign corner_x     = corner(hc_q[0], hoff_q[0], hoff_q[2], cnt_q);
	assign corner_y     = corner(hc_q[1], 33'sd0, hoff_q[3], cnt_q);
	assign corner_z     = corner(hc_q[2], hoff_q[1], hoff_q[4], cnt_q);

	`BCG_ASSERT(a_empty_out_takes_input, clk, arst_n, !out_valid |-> !in_stall)
	`BCG_ASSERT(a_waiting_out_holds_chain, clk, arst_n, (out_valid && out_stall) |-> in_stall)
	`BCG_ASSERT_NEXT(a_corner_advance, clk, arst_n, out_valid && !out_stall && !last_corner, out_valid && corner_index == $past(corner_index) + 2'd1)

endmodule
`default_nettype wire
